// ===== design/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the desk reminder scheduler: configuration
// register map, tick and event records, time constants.
// ----------------------------------------------------------------------------
package drs_pkg;

  // time constants
  localparam int unsigned MIN_PER_DAY = 1440;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned MS_PER_MIN  = SEC_PER_MIN * MS_PER_SEC;

  // field widths
  localparam int unsigned MOD_W    = 11;  // minute of day, also config width
  localparam int unsigned DAY_W    = 9;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SEC_W    = 32;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned CURMIN_W = 21;  // day*1440 + minute of day

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = MOD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_MIN   = 3'd0,
    REG_OFFWORK_MIN = 3'd1,
    REG_WORK_START  = 3'd2,
    REG_SEDENTARY   = 3'd3,
    REG_HYDRATION   = 3'd4,
    REG_QUOTE       = 3'd5,
    REG_MUTED       = 3'd6
  } cfg_idx_t;

  // reset values of the configuration registers
  localparam logic [MOD_W-1:0] RST_ALARM_MIN   = 11'd420;
  localparam logic [MOD_W-1:0] RST_OFFWORK_MIN = 11'd1080;
  localparam logic [MOD_W-1:0] RST_WORK_START  = 11'd540;
  localparam logic [MOD_W-1:0] RST_SEDENTARY   = 11'd60;
  localparam logic [MOD_W-1:0] RST_HYDRATION   = 11'd60;
  localparam logic [MOD_W-1:0] RST_QUOTE       = 11'd15;

  typedef struct packed {
    logic [MOD_W-1:0] alarm_min;
    logic [MOD_W-1:0] offwork_min;
    logic [MOD_W-1:0] work_start;
    logic [MOD_W-1:0] sit_limit;
    logic [MOD_W-1:0] drink_ivl;
    logic [MOD_W-1:0] quote_ivl;
    logic             muted;
  } cfg_t;

  // one scan tick
  typedef struct packed {
    logic                synced;
    logic [SEC_W-1:0]    unix_seconds;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [DAY_W-1:0]    day_of_year;
    logic [MS_W-1:0]     now_ms;
    logic                key_pressed;
  } tick_t;

  // one result
  typedef struct packed {
    logic alarm_event;
    logic alarm_sound;
    logic offwork_event;
    logic sedentary_event;
    logic hydration_event;
    logic quote_event;
  } evt_t;

endpackage

// ===== design/drs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// drs_cfg_regs
// Configuration register file: write-only, indexed, values masked to width.
// ----------------------------------------------------------------------------
module drs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [drs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output drs_pkg::cfg_t                   cfg
);
  import drs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ALARM_MIN:   cfg_nxt.alarm_min   = cfg_wdata;
        REG_OFFWORK_MIN: cfg_nxt.offwork_min = cfg_wdata;
        REG_WORK_START:  cfg_nxt.work_start  = cfg_wdata;
        REG_SEDENTARY:   cfg_nxt.sit_limit   = cfg_wdata;
        REG_HYDRATION:   cfg_nxt.drink_ivl   = cfg_wdata;
        REG_QUOTE:       cfg_nxt.quote_ivl   = cfg_wdata;
        REG_MUTED:       cfg_nxt.muted       = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_min   <= RST_ALARM_MIN;
      cfg_r.offwork_min <= RST_OFFWORK_MIN;
      cfg_r.work_start  <= RST_WORK_START;
      cfg_r.sit_limit   <= RST_SEDENTARY;
      cfg_r.drink_ivl   <= RST_HYDRATION;
      cfg_r.quote_ivl   <= RST_QUOTE;
      cfg_r.muted       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/drs_sched_core.sv =====
// ----------------------------------------------------------------------------
// drs_sched_core
// Scheduler state and per-tick decision logic: day tracking, daily alarm and
// off-work marks, sedentary idle timer, interval timers and minute claiming.
// ----------------------------------------------------------------------------
module drs_sched_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           tick_en,
  input  drs_pkg::tick_t tick,
  input  drs_pkg::cfg_t  cfg,
  output drs_pkg::evt_t  evt
);
  import drs_pkg::*;

  // state
  logic                day_seen_r, day_seen_nxt;
  logic [DAY_W-1:0]    last_day_r, last_day_nxt;
  logic                alarm_done_r, alarm_done_nxt;
  logic                offwork_done_r, offwork_done_nxt;
  logic                hyd_v_r, hyd_v_nxt;
  logic [SEC_W-1:0]    hyd_stamp_r, hyd_stamp_nxt;
  logic                quote_v_r, quote_v_nxt;
  logic [SEC_W-1:0]    quote_stamp_r, quote_stamp_nxt;
  logic                notice_v_r, notice_v_nxt;
  logic [CURMIN_W-1:0] notice_min_r, notice_min_nxt;
  logic [MS_W-1:0]     activity_r, activity_nxt;

  // decision terms
  logic [MOD_W-1:0]    mod;
  logic [CURMIN_W-1:0] cur_min;
  logic                new_day;
  logic                alarm_fire, offwork_fire, in_window;
  logic [MS_W-1:0]     act_eff, idle_ms, sed_thr;
  logic                sed_due;
  logic [SEC_W-1:0]    hyd_base, quote_base;
  logic [SEC_W:0]      hyd_diff, quote_diff;
  logic [SEC_W-1:0]    hyd_thr, quote_thr;
  logic                hyd_due, quote_due;
  logic                busy0, busy1, busy2;
  logic                sed_ev, hyd_ev, quote_ev;

  // time of day and minute index
  always_comb begin
    mod     = MOD_W'(tick.hour) * MOD_W'(SEC_PER_MIN) + MOD_W'(tick.minute);
    cur_min = CURMIN_W'(tick.day_of_year) * CURMIN_W'(MIN_PER_DAY) + CURMIN_W'(mod);
  end

  // daily alarm and off-work
  always_comb begin
    new_day      = !day_seen_r || (last_day_r != tick.day_of_year);
    alarm_fire   = !(alarm_done_r && !new_day) && (mod == cfg.alarm_min);
    offwork_fire = !(offwork_done_r && !new_day) && (mod == cfg.offwork_min);
    in_window    = (mod >= cfg.work_start) && (mod < cfg.offwork_min);
  end

  // sedentary idle timer, key press counts before the check
  always_comb begin
    act_eff = tick.key_pressed ? tick.now_ms : activity_r;
    idle_ms = tick.now_ms - act_eff;
    sed_thr = MS_W'(cfg.sit_limit) * MS_W'(MS_PER_MIN);
    sed_due = in_window && (idle_ms >= sed_thr);
  end

  // interval timers, signed difference so time going back never fires
  always_comb begin
    hyd_base   = hyd_v_r ? hyd_stamp_r : tick.unix_seconds;
    quote_base = quote_v_r ? quote_stamp_r : tick.unix_seconds;
    hyd_diff   = {1'b0, tick.unix_seconds} - {1'b0, hyd_base};
    quote_diff = {1'b0, tick.unix_seconds} - {1'b0, quote_base};
    hyd_thr    = SEC_W'(cfg.drink_ivl) * SEC_W'(SEC_PER_MIN);
    quote_thr  = SEC_W'(cfg.quote_ivl) * SEC_W'(SEC_PER_MIN);
    hyd_due    = in_window && !hyd_diff[SEC_W] && (hyd_diff[SEC_W-1:0] >= hyd_thr);
    quote_due  = in_window && !quote_diff[SEC_W] && (quote_diff[SEC_W-1:0] >= quote_thr);
  end

  // one notice per minute, claimed in priority order
  always_comb begin
    busy0    = alarm_fire || offwork_fire || (notice_v_r && (notice_min_r == cur_min));
    sed_ev   = sed_due && !busy0;
    busy1    = busy0 || sed_due;
    hyd_ev   = hyd_due && !busy1;
    busy2    = busy1 || hyd_due;
    quote_ev = quote_due && !busy2;
  end

  // result
  always_comb begin
    evt                 = '0;
    evt.alarm_event     = tick.synced && alarm_fire;
    evt.alarm_sound     = tick.synced && alarm_fire && !cfg.muted;
    evt.offwork_event   = tick.synced && offwork_fire;
    evt.sedentary_event = tick.synced && sed_ev;
    evt.hydration_event = tick.synced && hyd_ev;
    evt.quote_event     = tick.synced && quote_ev;
  end

  // next state
  always_comb begin
    day_seen_nxt     = day_seen_r;
    last_day_nxt     = last_day_r;
    alarm_done_nxt   = alarm_done_r;
    offwork_done_nxt = offwork_done_r;
    hyd_v_nxt        = hyd_v_r;
    hyd_stamp_nxt    = hyd_stamp_r;
    quote_v_nxt      = quote_v_r;
    quote_stamp_nxt  = quote_stamp_r;
    notice_v_nxt     = notice_v_r;
    notice_min_nxt   = notice_min_r;
    activity_nxt     = act_eff;
    if (tick.synced) begin
      day_seen_nxt     = 1'b1;
      last_day_nxt     = tick.day_of_year;
      alarm_done_nxt   = (alarm_done_r && !new_day) || alarm_fire;
      offwork_done_nxt = (offwork_done_r && !new_day) || offwork_fire;
      if (alarm_fire || offwork_fire || sed_ev || hyd_ev || quote_ev) begin
        notice_v_nxt   = 1'b1;
        notice_min_nxt = cur_min;
      end
      if (in_window) begin
        hyd_v_nxt   = 1'b1;
        quote_v_nxt = 1'b1;
        if (hyd_due || !hyd_v_r) begin
          hyd_stamp_nxt = tick.unix_seconds;
        end
        if (quote_due || !quote_v_r) begin
          quote_stamp_nxt = tick.unix_seconds;
        end
      end
      if (sed_due) begin
        activity_nxt = tick.now_ms;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_seen_r     <= 1'b0;
      alarm_done_r   <= 1'b0;
      offwork_done_r <= 1'b0;
      hyd_v_r        <= 1'b0;
      quote_v_r      <= 1'b0;
      notice_v_r     <= 1'b0;
      activity_r     <= '0;
    end else if (tick_en) begin
      day_seen_r     <= day_seen_nxt;
      alarm_done_r   <= alarm_done_nxt;
      offwork_done_r <= offwork_done_nxt;
      hyd_v_r        <= hyd_v_nxt;
      quote_v_r      <= quote_v_nxt;
      notice_v_r     <= notice_v_nxt;
      activity_r     <= activity_nxt;
    end
  end

  // stamps, qualified by the valid bits above
  always_ff @(posedge clk) begin
    if (tick_en) begin
      last_day_r    <= last_day_nxt;
      hyd_stamp_r   <= hyd_stamp_nxt;
      quote_stamp_r <= quote_stamp_nxt;
      notice_min_r  <= notice_min_nxt;
    end
  end

endmodule

// ===== design/desk_reminder_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// desk_reminder_scheduler_unit: desk reminder scheduler top level
// Path: a tick transfer is captured in the input register, evaluated by the
// scheduler core, and its result is captured in the output register.
// Throughput: one tick per cycle unless the output stalls; one evaluation stage.
// Reset: synchronous; config takes defaults, all day and timer marks clear.
// ----------------------------------------------------------------------------
module desk_reminder_scheduler_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [drs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // tick input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_synced,
  input  logic [drs_pkg::SEC_W-1:0]       in_unix_seconds,
  input  logic [drs_pkg::HOUR_W-1:0]      in_hour,
  input  logic [drs_pkg::MINUTE_W-1:0]    in_minute,
  input  logic [drs_pkg::DAY_W-1:0]       in_day_of_year,
  input  logic [drs_pkg::MS_W-1:0]        in_now_ms,
  input  logic                            in_key_pressed,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_alarm_event,
  output logic                            out_alarm_sound,
  output logic                            out_offwork_event,
  output logic                            out_sedentary_event,
  output logic                            out_hydration_event,
  output logic                            out_quote_event
);
  import drs_pkg::*;

  cfg_t  cfg;
  tick_t tick_r;
  logic  tick_vld_r, tick_vld_nxt;
  evt_t  evt;
  evt_t  out_r;
  logic  out_vld_r, out_vld_nxt;
  logic  advance, in_xfer;

  drs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: evaluation stage moves when the output register is free
  always_comb begin
    advance      = !out_vld_r || out_ready;
    in_ready     = !tick_vld_r || advance;
    in_xfer      = in_valid && in_ready;
    tick_vld_nxt = in_xfer || (tick_vld_r && !advance);
    out_vld_nxt  = advance ? tick_vld_r : out_vld_r;
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tick_r.synced       <= in_synced;
      tick_r.unix_seconds <= in_unix_seconds;
      tick_r.hour         <= in_hour;
      tick_r.minute       <= in_minute;
      tick_r.day_of_year  <= in_day_of_year;
      tick_r.now_ms       <= in_now_ms;
      tick_r.key_pressed  <= in_key_pressed;
    end
  end

  drs_sched_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_vld_r && advance),
    .tick    (tick_r),
    .cfg     (cfg),
    .evt     (evt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance && tick_vld_r) begin
      out_r <= evt;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      tick_vld_r <= tick_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_alarm_event     = out_r.alarm_event;
  assign out_alarm_sound     = out_r.alarm_sound;
  assign out_offwork_event   = out_r.offwork_event;
  assign out_sedentary_event = out_r.sedentary_event;
  assign out_hydration_event = out_r.hydration_event;
  assign out_quote_event     = out_r.quote_event;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: desk reminder scheduler unit check
// Drives scan ticks through the valid/ready input with random bursts and gaps,
// stalls the result channel on its own pattern, and compares every result
// against a cycle-free predictor of alarm, off-work and reminder events.
// Register settings change between phases while the unit is drained.
// ----------------------------------------------------------------------------
module testbench;
  import drs_pkg::*;

  // index past the last register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned PHASE_TICKS = 122;

  typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts the events of each tick and checks the results
  // --------------------------------------------------------------------------
  class reminder_scoreboard;
    // register copies
    logic [MOD_W-1:0] alarm_at, leave_at, work_from;
    logic [MOD_W-1:0] sit_limit, drink_every, quote_every;
    logic             mute;
    // day marks, interval timers and the minute claim
    bit               day_armed, alarm_armed, leave_armed;
    bit               drink_armed, quote_armed, notice_armed;
    logic [DAY_W-1:0] seen_day, alarm_day, leave_day;
    logic [SEC_W-1:0] drink_stamp, quote_stamp;
    int unsigned      notice_min;
    logic [MS_W-1:0]  idle_ref_ms;
    evt_t             pending_events[$];
    int               errors;
    int               results_seen;

    function new();
      alarm_at     = RST_ALARM_MIN;
      leave_at     = RST_OFFWORK_MIN;
      work_from    = RST_WORK_START;
      sit_limit    = RST_SEDENTARY;
      drink_every  = RST_HYDRATION;
      quote_every  = RST_QUOTE;
      mute         = 1'b0;
      day_armed    = 1'b0;
      alarm_armed  = 1'b0;
      leave_armed  = 1'b0;
      drink_armed  = 1'b0;
      quote_armed  = 1'b0;
      notice_armed = 1'b0;
      seen_day     = '0;
      alarm_day    = '0;
      leave_day    = '0;
      drink_stamp  = '0;
      quote_stamp  = '0;
      notice_min   = 0;
      idle_ref_ms  = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MOD_W-1:0] v);
      case (idx)
        REG_ALARM_MIN:   alarm_at = v;
        REG_OFFWORK_MIN: leave_at = v;
        REG_WORK_START:  work_from = v;
        REG_SEDENTARY:   sit_limit = v;
        REG_HYDRATION:   drink_every = v;
        REG_QUOTE:       quote_every = v;
        REG_MUTED:       mute = v[0];
        default:         ;
      endcase
    endfunction

    // one notice per wall-clock minute
    function bit take_minute(int unsigned m);
      if (notice_armed && notice_min == m)
        return 1'b0;
      notice_armed = 1'b1;
      notice_min = m;
      return 1'b1;
    endfunction

    // signed second difference, so a clock going backward never fires
    function bit interval_due(inout bit armed, inout logic [SEC_W-1:0] stamp,
                              input logic [SEC_W-1:0] now_s,
                              input logic [MOD_W-1:0] mins);
      longint gap_s;
      if (!armed) begin
        armed = 1'b1;
        stamp = now_s;
      end
      gap_s = longint'({32'd0, now_s}) - longint'({32'd0, stamp});
      if (gap_s >= longint'({53'd0, mins}) * 60) begin
        stamp = now_s;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // accepted tick transfer: work out its events
    function void note_tick(tick_t t);
      evt_t            e;
      int unsigned     mod_now;
      int unsigned     cur_min;
      logic [MS_W-1:0] idle_ms;
      e = '0;
      if (t.key_pressed)
        idle_ref_ms = t.now_ms;
      if (t.synced) begin
        // new day clears the daily marks
        if (!day_armed || seen_day != t.day_of_year) begin
          day_armed   = 1'b1;
          seen_day    = t.day_of_year;
          alarm_armed = 1'b0;
          leave_armed = 1'b0;
        end
        mod_now = int'(t.hour) * 60 + int'(t.minute);
        cur_min = int'(t.day_of_year) * MIN_PER_DAY + mod_now;
        if (!(alarm_armed && alarm_day == t.day_of_year) && mod_now == alarm_at) begin
          alarm_armed   = 1'b1;
          alarm_day     = t.day_of_year;
          e.alarm_event = 1'b1;
          e.alarm_sound = !mute;
          notice_armed  = 1'b1;
          notice_min    = cur_min;
        end
        if (!(leave_armed && leave_day == t.day_of_year) && mod_now == leave_at) begin
          leave_armed     = 1'b1;
          leave_day       = t.day_of_year;
          e.offwork_event = 1'b1;
          notice_armed    = 1'b1;
          notice_min      = cur_min;
        end
        // reminders only inside the work window
        if (mod_now >= work_from && mod_now < leave_at) begin
          idle_ms = t.now_ms - idle_ref_ms;
          if (idle_ms >= MS_W'(sit_limit * MS_PER_MIN)) begin
            idle_ref_ms = t.now_ms;
            if (take_minute(cur_min))
              e.sedentary_event = 1'b1;
          end
          if (interval_due(drink_armed, drink_stamp, t.unix_seconds, drink_every))
            if (take_minute(cur_min))
              e.hydration_event = 1'b1;
          if (interval_due(quote_armed, quote_stamp, t.unix_seconds, quote_every))
            if (take_minute(cur_min))
              e.quote_event = 1'b1;
        end
      end
      pending_events.push_back(e);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_bit(string name, logic got_b, logic want_b);
      if (got_b !== want_b)
        report_mismatch($sformatf("result %0d %s got %b expected %b",
                                  results_seen, name, got_b, want_b));
    endtask

    // accepted result transfer against the oldest expectation
    task check_result(evt_t got);
      evt_t want;
      results_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", results_seen));
        return;
      end
      want = pending_events.pop_front();
      compare_bit("alarm_event", got.alarm_event, want.alarm_event);
      compare_bit("alarm_sound", got.alarm_sound, want.alarm_sound);
      compare_bit("offwork_event", got.offwork_event, want.offwork_event);
      compare_bit("sedentary_event", got.sedentary_event, want.sedentary_event);
      compare_bit("hydration_event", got.hydration_event, want.hydration_event);
      compare_bit("quote_event", got.quote_event, want.quote_event);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and instance
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_synced = 1'b0;
  logic [SEC_W-1:0]      in_unix_seconds = '0;
  logic [HOUR_W-1:0]     in_hour = '0;
  logic [MINUTE_W-1:0]   in_minute = '0;
  logic [DAY_W-1:0]      in_day_of_year = '0;
  logic [MS_W-1:0]       in_now_ms = '0;
  logic                  in_key_pressed = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_alarm_event, out_alarm_sound, out_offwork_event;
  logic                  out_sedentary_event, out_hydration_event, out_quote_event;

  reminder_scoreboard sb;

  // stimulus wall clock
  int               cur_day, cur_sod;
  logic [SEC_W-1:0] cur_unix;
  logic [MS_W-1:0]  cur_ms;

  // result stall pattern
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       rx_hold = 0;

  desk_reminder_scheduler_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_synced           (in_synced),
    .in_unix_seconds     (in_unix_seconds),
    .in_hour             (in_hour),
    .in_minute           (in_minute),
    .in_day_of_year      (in_day_of_year),
    .in_now_ms           (in_now_ms),
    .in_key_pressed      (in_key_pressed),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_alarm_event     (out_alarm_event),
    .out_alarm_sound     (out_alarm_sound),
    .out_offwork_event   (out_offwork_event),
    .out_sedentary_event (out_sedentary_event),
    .out_hydration_event (out_hydration_event),
    .out_quote_event     (out_quote_event)
  );

  // clock
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  function automatic tick_t mk_tick(bit sync, logic [SEC_W-1:0] secs, int hh, int mm,
                                    int dd, logic [MS_W-1:0] ms, bit key);
    tick_t t;
    t.synced       = sync;
    t.unix_seconds = secs;
    t.hour         = HOUR_W'(hh);
    t.minute       = MINUTE_W'(mm);
    t.day_of_year  = DAY_W'(dd);
    t.now_ms       = ms;
    t.key_pressed  = key;
    return t;
  endfunction

  // hold the tick until its transfer
  task automatic send_tick(tick_t t);
    @(negedge clk);
    in_valid        = 1'b1;
    in_synced       = t.synced;
    in_unix_seconds = t.unix_seconds;
    in_hour         = t.hour;
    in_minute       = t.minute;
    in_day_of_year  = t.day_of_year;
    in_now_ms       = t.now_ms;
    in_key_pressed  = t.key_pressed;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_tick(t);
  endtask

  // stop sending and wait for every expected result
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only while drained
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(val);
    sb.write_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: stall pattern and monitor
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(40, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE: out_ready = 1'b1;
      RX_RANDOM: out_ready = ($urandom_range(0, 2) != 0);
      default: begin
        if (rx_hold == 0) begin
          out_ready = !out_ready;
          rx_hold = out_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
        end
        rx_hold--;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_result({out_alarm_event, out_alarm_sound, out_offwork_event,
                       out_sedentary_event, out_hydration_event, out_quote_event});
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          p, n, secs, r, burst_left, gap, base_min;
    int unsigned ws;
    sb = new();
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: unsynced key press with every field at its top
    send_tick(mk_tick(1'b0, 32'hFFFF_FFFF, 31, 63, 511, 32'hFFFF_FFFF, 1'b1));
    // alarm through an out-of-range minute, then once per day only
    send_tick(mk_tick(1'b1, 32'd100, 6, 60, 0, 32'd0, 1'b0));
    send_tick(mk_tick(1'b1, 32'd160, 7, 0, 0, 32'd60000, 1'b0));
    send_tick(mk_tick(1'b1, 32'd200, 7, 0, 1, 32'd70000, 1'b0));
    // sedentary over the ms wrap, then timers yielding their minute
    send_tick(mk_tick(1'b1, 32'd1000, 9, 0, 1, 32'd3599999, 1'b0));
    send_tick(mk_tick(1'b1, 32'd4600, 9, 0, 1, 32'd3600500, 1'b0));
    send_tick(mk_tick(1'b1, 32'd5500, 9, 1, 1, 32'd3601000, 1'b0));
    // clock going backward
    send_tick(mk_tick(1'b1, 32'd0, 9, 2, 1, 32'd3602000, 1'b1));
    // off-work greeting at the window end
    send_tick(mk_tick(1'b1, 32'd10, 18, 0, 1, 32'd3603000, 1'b0));
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 31, 63, 365, 32'd0, 1'b0));
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 17, 59, 365, 32'd1000, 1'b0));

    // muted alarm inside the window, zero intervals, dropped write
    quiesce();
    set_reg(REG_MUTED, 1);
    set_reg(REG_ALARM_MIN, 600);
    set_reg(REG_HYDRATION, 0);
    set_reg(REG_QUOTE, 0);
    set_reg(REG_UNUSED, 11'h7FF);
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 10, 0, 2, 32'd5000, 1'b0));
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 10, 1, 2, 32'd6000, 1'b0));
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 10, 1, 2, 32'd7000, 1'b1));

    // empty work window, then the widest one with a zero idle limit
    quiesce();
    set_reg(REG_WORK_START, 1080);
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 12, 0, 2, 32'd8000, 1'b0));
    quiesce();
    set_reg(REG_WORK_START, 0);
    set_reg(REG_OFFWORK_MIN, 1439);
    set_reg(REG_SEDENTARY, 0);
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 0, 0, 3, 32'd9000, 1'b0));
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 0, 1, 3, 32'd9500, 1'b0));
    send_tick(mk_tick(1'b1, 32'd20, 23, 59, 3, 32'd9900, 1'b0));

    // random phases: walking wall clock with some noise ticks
    cur_unix = $urandom;
    cur_ms = $urandom;
    for (p = 0; p < 6; p++) begin
      quiesce();
      case (p)
        0: begin
          set_reg(REG_ALARM_MIN, 0);
          set_reg(REG_OFFWORK_MIN, 1439);
          set_reg(REG_WORK_START, 0);
          set_reg(REG_SEDENTARY, 1);
          set_reg(REG_HYDRATION, 1);
          set_reg(REG_QUOTE, 1);
          set_reg(REG_MUTED, 0);
          cur_day = 365;
          base_min = 1430;
        end
        1: begin
          set_reg(REG_ALARM_MIN, 1439);
          set_reg(REG_OFFWORK_MIN, 1439);
          set_reg(REG_WORK_START, 1439);
          set_reg(REG_SEDENTARY, 1440);
          set_reg(REG_HYDRATION, 1440);
          set_reg(REG_QUOTE, 1440);
          set_reg(REG_MUTED, 1);
          cur_day = $urandom_range(0, 365);
          base_min = 1425;
        end
        default: begin
          ws = $urandom_range(0, 1380);
          set_reg(REG_WORK_START, ws);
          set_reg(REG_OFFWORK_MIN, ws + $urandom_range(5, 45));
          set_reg(REG_ALARM_MIN, ws + $urandom_range(0, 45));
          set_reg(REG_SEDENTARY, $urandom_range(1, 6));
          set_reg(REG_HYDRATION, $urandom_range(1, 10));
          set_reg(REG_QUOTE, $urandom_range(1, 6));
          set_reg(REG_MUTED, $urandom_range(0, 1));
          cur_day = $urandom_range(0, 365);
          base_min = (ws >= 3) ? int'(ws) - 3 : 0;
        end
      endcase
      cur_sod = base_min * 60 + $urandom_range(0, 59);

      for (n = 0; n < PHASE_TICKS; n++) begin
        // sender bursts with gaps between them
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;

        if ($urandom_range(0, 9) == 0) begin
          // noise: any value the fields can carry
          send_tick(mk_tick($urandom_range(0, 1), $urandom, $urandom_range(0, 31),
                            $urandom_range(0, 63), $urandom_range(0, 511), $urandom,
                            $urandom_range(0, 1)));
        end else begin
          // advance the wall clock, mostly by less than a minute
          r = $urandom_range(0, 99);
          secs = (r < 80) ? $urandom_range(0, 40) :
                 (r < 95) ? $urandom_range(41, 300) : $urandom_range(301, 3600);
          cur_sod += secs;
          cur_unix += SEC_W'(secs);
          cur_ms += MS_W'(secs * 1000 + $urandom_range(0, 999));
          while (cur_sod >= 86400) begin
            cur_sod -= 86400;
            cur_day = (cur_day == 365) ? 0 : cur_day + 1;
          end
          send_tick(mk_tick($urandom_range(0, 19) != 0, cur_unix, cur_sod / 3600,
                            (cur_sod / 60) % 60, cur_day, cur_ms,
                            $urandom_range(0, 24) == 0));
        end
      end
    end

    // drain and let the pipeline settle
    quiesce();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_events.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
